[rtl/countdown_timer_strike_rate_defines.svh]
// assertion macros shared by the countdown timer rtl
`ifndef COUNTDOWN_TIMER_STRIKE_RATE_DEFINES_SVH
`define COUNTDOWN_TIMER_STRIKE_RATE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CDTSR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds outside reset
`define CDTSR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> !(cond)) \
        else $error(msg);

`endif

[rtl/cdtsr_pkg.sv]
// shared types and constants of the countdown timer
package cdtsr_pkg;

    localparam int unsigned DEF_TICKS_PER_SECOND = 1000000;

    localparam int TIME_W    = 31;
    localparam int ELAPSED_W = 24;
    localparam int STRIKE_W  = 3;
    localparam int LIM_W     = 2;
    localparam int DIGIT_W   = 4;
    localparam int LED_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0]    GAME_LEN_RESET   = 31'd300000000;
    localparam logic [LIM_W-1:0]     STRIKE_LIM_RESET = 2'd3;
    localparam logic [STRIKE_W-1:0]  STRIKE_MAX       = 3'd7;
    localparam logic [LED_W-1:0]     LED_BOTH_ON      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GAME_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT = 2'd1;

    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 16;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_ADD   = 2'd2,
        REQ_SET   = 2'd3
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0]   remaining;
        logic [STRIKE_W-1:0] strikes;
        logic                tick;
        logic                limit;
    } t_job;

    typedef struct packed {
        logic [DIGIT_W-1:0]  digit_a;
        logic [DIGIT_W-1:0]  digit_b;
        logic [DIGIT_W-1:0]  digit_c;
        logic [DIGIT_W-1:0]  digit_d;
        logic                colon_on;
        logic                expired;
        logic                limit_reached;
        logic                display_changed;
        logic [STRIKE_W-1:0] strikes_now;
        logic [LED_W-1:0]    led_mode;
    } t_result;

endpackage

[rtl/cdtsr_fifo.sv]
// small register fifo with show-ahead read, depth a power of two
module cdtsr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[rtl/cdtsr_cdiv.sv]
// pipelined divide by a constant: reciprocal multiply, back multiply, one correction
module cdtsr_cdiv #(
    parameter int              W  = 31,
    parameter longint unsigned D  = 10,
    parameter int              QW = 31,
    parameter int              RW = 4
) (
    input  logic          i_clk,
    input  logic [W-1:0]  i_x,
    output logic [QW-1:0] o_q,
    output logic [RW-1:0] o_r
);
    // floor(2^W / D) leaves the estimate at most one short
    localparam longint unsigned RECIP = (64'd1 << W) / D;
    localparam logic [W-1:0]    M     = W'(RECIP);
    localparam logic [W-1:0]    DW    = W'(D);

    logic [2*W-1:0] prod;
    logic [W-1:0]   r_x1;
    logic [W-1:0]   r_q1;
    logic [W-1:0]   r_x2;
    logic [W-1:0]   r_q2;
    logic [W-1:0]   r_p2;
    logic [W-1:0]   rem0;
    logic           fix;
    logic [QW-1:0]  r_q;
    logic [RW-1:0]  r_r;

    assign prod = (2*W)'(i_x) * (2*W)'(M);

    always_ff @(posedge i_clk) begin
        r_x1 <= i_x;
        r_q1 <= prod[2*W-1:W];
        r_x2 <= r_x1;
        r_q2 <= r_q1;
        r_p2 <= W'(r_q1 * DW);
    end

    assign rem0 = r_x2 - r_p2;
    assign fix  = (rem0 >= DW);

    always_ff @(posedge i_clk) begin
        r_q <= QW'(fix ? (r_q2 + W'(1)) : r_q2);
        r_r <= RW'(fix ? (rem0 - DW) : rem0);
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

[rtl/cdtsr_front.sv]
// front end: takes items, holds time and strike state, queues jobs for display
module cdtsr_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic [1:0]                           i_req_type,
    input  logic [cdtsr_pkg::ELAPSED_W-1:0]      i_elapsed_us,
    input  logic [cdtsr_pkg::STRIKE_W-1:0]       i_strike_amount,
    input  logic                                 i_cfg_valid,
    input  logic [cdtsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cdtsr_pkg::TIME_W-1:0]         i_cfg_data,
    input  logic                                 i_job_full,
    output logic                                 o_job_push,
    output cdtsr_pkg::t_job                      o_job
);
    import cdtsr_pkg::*;

    localparam int FACT_W = 4;
    localparam int PROD_W = ELAPSED_W + FACT_W;
    localparam int DEC_W  = PROD_W - 2;

    logic [TIME_W-1:0]   r_game_len;
    logic [LIM_W-1:0]    r_strike_lim;
    logic [TIME_W-1:0]   r_remaining;
    logic [STRIKE_W-1:0] r_strikes;
    logic [TIME_W-1:0]   n_game_len;
    logic [LIM_W-1:0]    n_strike_lim;
    logic [TIME_W-1:0]   n_remaining;
    logic [STRIKE_W-1:0] n_strikes;

    logic                accept;
    t_req                req;
    logic [FACT_W-1:0]   factor;
    logic [PROD_W-1:0]   prod;
    logic [DEC_W-1:0]    dec;
    logic [STRIKE_W:0]   sum;

    assign accept = i_push && !i_job_full;
    assign req    = t_req'(i_req_type);

    // rate goes up by a quarter per strike, rounded up
    assign factor = FACT_W'(4) + FACT_W'(r_strikes);
    assign prod   = PROD_W'(i_elapsed_us) * PROD_W'(factor);
    assign dec    = DEC_W'((prod + PROD_W'(3)) >> 2);
    assign sum    = (STRIKE_W+1)'(r_strikes) + (STRIKE_W+1)'(i_strike_amount);

    always_comb begin
        n_game_len   = r_game_len;
        n_strike_lim = r_strike_lim;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAME_LEN:     n_game_len   = i_cfg_data;
                CFG_STRIKE_LIMIT: n_strike_lim = i_cfg_data[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        n_remaining = r_remaining;
        n_strikes   = r_strikes;
        if (accept) begin
            unique case (req)
                REQ_START: n_remaining = r_game_len;
                REQ_TICK: begin
                    if (TIME_W'(dec) >= r_remaining) begin
                        n_remaining = '0;
                    end else begin
                        n_remaining = r_remaining - TIME_W'(dec);
                    end
                end
                REQ_ADD: begin
                    if (sum > (STRIKE_W+1)'(STRIKE_MAX)) begin
                        n_strikes = STRIKE_MAX;
                    end else begin
                        n_strikes = sum[STRIKE_W-1:0];
                    end
                end
                REQ_SET: n_strikes = i_strike_amount;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_game_len   <= GAME_LEN_RESET;
            r_strike_lim <= STRIKE_LIM_RESET;
            r_remaining  <= '0;
            r_strikes    <= '0;
        end else begin
            r_game_len   <= n_game_len;
            r_strike_lim <= n_strike_lim;
            r_remaining  <= n_remaining;
            r_strikes    <= n_strikes;
        end
    end

    assign o_job_push      = accept;
    assign o_job.remaining = n_remaining;
    assign o_job.strikes   = n_strikes;
    assign o_job.tick      = accept && (req == REQ_TICK);
    assign o_job.limit     = (n_strikes >= STRIKE_W'(r_strike_lim));

endmodule

[rtl/cdtsr_back.sv]
// back end: turns remaining time into display digits and flags, ten pipeline stages
module cdtsr_back #(
    parameter int unsigned TICKS_PER_SECOND = cdtsr_pkg::DEF_TICKS_PER_SECOND
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_empty,
    input  cdtsr_pkg::t_job      i_job,
    output logic                 o_job_pop,
    output logic                 o_res_push,
    output cdtsr_pkg::t_result   o_res,
    input  logic                 i_res_pop
);
    import cdtsr_pkg::*;

    localparam longint unsigned T_L       = TICKS_PER_SECOND;
    localparam longint unsigned TENTH_L   = T_L / 10;
    localparam longint unsigned HUND_L    = T_L / 100;
    localparam longint unsigned MINUTE_L  = 60 * T_L;
    localparam longint unsigned TIME_MAX  = (64'd1 << TIME_W) - 1;
    localparam int SEC_W   = $clog2(TIME_MAX / T_L + 1);
    localparam int FRAC_W  = $clog2(T_L);
    localparam int MIN_W   = $clog2(((64'd1 << SEC_W) - 1) / 60 + 1);
    localparam int TEN_W   = $clog2(((64'd1 << MIN_W) - 1) / 10 + 1);
    localparam int SUB_W   = $clog2(MINUTE_L);
    localparam int SUBQ_W  = $clog2(((64'd1 << SUB_W) - 1) / TENTH_L + 1);
    localparam int TENR_W  = $clog2(TENTH_L);
    localparam int SECR_W  = $clog2(60);
    localparam int LAST    = 9;
    localparam int CRED_W  = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic                zero;
        logic                ge_min;
        logic                tick;
        logic                limit;
        logic [STRIKE_W-1:0] strikes;
    } t_side;

    logic [CRED_W-1:0]  r_used;
    logic               issue;
    logic [LAST:0]      r_vld;
    t_job               r_job0;
    t_side              n_side0;
    t_side              r_side [1:LAST];

    logic [SEC_W-1:0]   sec_q;
    logic [FRAC_W-1:0]  frac_r;
    logic [TENR_W-1:0]  tenth_r;
    logic [MIN_W-1:0]   min_q;
    logic [SECR_W-1:0]  sec_r;
    logic [TEN_W-1:0]   tens_q;
    logic [DIGIT_W-1:0] mins_r;

    logic [DIGIT_W-1:0] n_frac_c;
    logic [DIGIT_W-1:0] n_frac_d;
    logic [DIGIT_W-1:0] r_frac_c [4:LAST];
    logic [DIGIT_W-1:0] r_frac_d [4:LAST];
    logic [DIGIT_W-1:0] n_sec_t;
    logic [DIGIT_W-1:0] n_sec_o;
    logic [DIGIT_W-1:0] r_sec_t [7:LAST];
    logic [DIGIT_W-1:0] r_sec_o [7:LAST];

    logic [4*DIGIT_W-1:0] r_prev;
    logic [4*DIGIT_W-1:0] shown;
    logic                 changed;
    t_side                side_l;
    t_result              res;

    // credit covers every item in flight plus those parked in the result queue
    assign issue     = !i_job_empty && (r_used != CRED_W'(OUT_DEPTH));
    assign o_job_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_vld  <= '0;
        end else begin
            r_used <= r_used + CRED_W'(issue) - CRED_W'(i_res_pop);
            r_vld  <= {r_vld[LAST-1:0], issue};
        end
    end

    always_ff @(posedge i_clk) begin
        r_job0 <= i_job;
    end

    always_comb begin
        n_side0.zero    = (r_job0.remaining == '0);
        n_side0.ge_min  = (r_job0.remaining >= TIME_W'(MINUTE_L));
        n_side0.tick    = r_job0.tick;
        n_side0.limit   = r_job0.limit;
        n_side0.strikes = r_job0.strikes;
    end

    always_ff @(posedge i_clk) begin
        r_side[1] <= n_side0;
        for (int k = 2; k <= LAST; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // stage 0 -> 3: whole seconds and ticks within the second
    cdtsr_cdiv #(.W(TIME_W), .D(T_L), .QW(SEC_W), .RW(FRAC_W)) u_div_sec (
        .i_clk (i_clk),
        .i_x   (r_job0.remaining),
        .o_q   (sec_q),
        .o_r   (frac_r)
    );

    // stage 0 -> 3: ticks within the tenth, only meaningful under a minute
    cdtsr_cdiv #(.W(SUB_W), .D(TENTH_L), .QW(SUBQ_W), .RW(TENR_W)) u_div_tenth (
        .i_clk (i_clk),
        .i_x   (r_job0.remaining[SUB_W-1:0]),
        .o_q   (),
        .o_r   (tenth_r)
    );

    // stage 3 -> 6: minutes and seconds within the minute
    cdtsr_cdiv #(.W(SEC_W), .D(64'd60), .QW(MIN_W), .RW(SECR_W)) u_div_min (
        .i_clk (i_clk),
        .i_x   (sec_q),
        .o_q   (min_q),
        .o_r   (sec_r)
    );

    // stage 6 -> 9: tens of minutes and minutes
    cdtsr_cdiv #(.W(MIN_W), .D(64'd10), .QW(TEN_W), .RW(DIGIT_W)) u_div_ten (
        .i_clk (i_clk),
        .i_x   (min_q),
        .o_q   (tens_q),
        .o_r   (mins_r)
    );

    // tenths and hundredths, counting thresholds gives the clamp at nine for free
    always_comb begin
        n_frac_c = '0;
        n_frac_d = '0;
        for (int k = 1; k <= 9; k++) begin
            if (64'(frac_r) >= 64'(k) * TENTH_L) begin
                n_frac_c = n_frac_c + DIGIT_W'(1);
            end
            if (64'(tenth_r) >= 64'(k) * HUND_L) begin
                n_frac_d = n_frac_d + DIGIT_W'(1);
            end
        end
    end

    always_comb begin
        n_sec_t = '0;
        for (int k = 1; k <= 5; k++) begin
            if (sec_r >= SECR_W'(10 * k)) begin
                n_sec_t = n_sec_t + DIGIT_W'(1);
            end
        end
        n_sec_o = DIGIT_W'(sec_r - SECR_W'(n_sec_t) * SECR_W'(10));
    end

    always_ff @(posedge i_clk) begin
        r_frac_c[4] <= n_frac_c;
        r_frac_d[4] <= n_frac_d;
        for (int k = 5; k <= LAST; k++) begin
            r_frac_c[k] <= r_frac_c[k-1];
            r_frac_d[k] <= r_frac_d[k-1];
        end
        r_sec_t[7] <= n_sec_t;
        r_sec_o[7] <= n_sec_o;
        for (int k = 8; k <= LAST; k++) begin
            r_sec_t[k] <= r_sec_t[k-1];
            r_sec_o[k] <= r_sec_o[k-1];
        end
    end

    assign side_l = r_side[LAST];

    always_comb begin
        res = '0;
        if (side_l.zero) begin
            res.digit_a = '0;
        end else if (side_l.ge_min) begin
            res.digit_a = (32'(tens_q) >= 32'd9) ? DIGIT_W'(9) : DIGIT_W'(tens_q);
            res.digit_b = mins_r;
            res.digit_c = r_sec_t[LAST];
            res.digit_d = r_sec_o[LAST];
        end else begin
            res.digit_a = r_sec_t[LAST];
            res.digit_b = r_sec_o[LAST];
            res.digit_c = r_frac_c[LAST];
            res.digit_d = r_frac_d[LAST];
        end
        shown = {res.digit_a, res.digit_b, res.digit_c, res.digit_d};
        // under a minute only the seconds pair counts as a change
        if (side_l.ge_min) begin
            changed = side_l.tick && (shown != r_prev);
        end else begin
            changed = side_l.tick &&
                      (shown[4*DIGIT_W-1:2*DIGIT_W] != r_prev[4*DIGIT_W-1:2*DIGIT_W]);
        end
        res.colon_on        = !side_l.zero;
        res.expired         = side_l.zero;
        res.limit_reached   = side_l.limit;
        res.display_changed = changed;
        res.strikes_now     = side_l.strikes;
        res.led_mode        = (side_l.strikes >= STRIKE_W'(LED_BOTH_ON)) ?
                              LED_BOTH_ON : side_l.strikes[LED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (r_vld[LAST] && changed) begin
            r_prev <= shown;
        end
    end

    assign o_res_push = r_vld[LAST];
    assign o_res      = res;

endmodule

[rtl/countdown_timer_strike_rate.sv]
// Countdown timer with strike-scaled rate and mm:ss / ss.hh digit readout. One item is
// taken per clock while the job queue is not full: the front end updates the remaining
// time and strike count in the cycle an item is accepted and drops a job into a two-entry
// queue; the back end is a ten-stage pipeline of constant-divisor units (reciprocal
// multiply, back multiply, one correction) that splits the time into digits, and its
// results park in a sixteen-entry result queue. The back end keeps issuing as long as
// fewer than sixteen results are in flight or waiting, so with pop held high the block
// sustains one item per cycle. Configuration writes are always ready and take effect at once.
`include "countdown_timer_strike_rate_defines.svh"

module countdown_timer_strike_rate #(
    parameter int unsigned TICKS_PER_SECOND = cdtsr_pkg::DEF_TICKS_PER_SECOND
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_req_type,
    input  logic [cdtsr_pkg::ELAPSED_W-1:0]   i_elapsed_us,
    input  logic [cdtsr_pkg::STRIKE_W-1:0]    i_strike_amount,
    output logic                              empty,
    input  logic                              pop,
    output logic [cdtsr_pkg::DIGIT_W-1:0]     o_digit_a,
    output logic [cdtsr_pkg::DIGIT_W-1:0]     o_digit_b,
    output logic [cdtsr_pkg::DIGIT_W-1:0]     o_digit_c,
    output logic [cdtsr_pkg::DIGIT_W-1:0]     o_digit_d,
    output logic                              o_colon_on,
    output logic                              o_expired,
    output logic                              o_limit_reached,
    output logic                              o_display_changed,
    output logic [cdtsr_pkg::STRIKE_W-1:0]    o_strikes_now,
    output logic [cdtsr_pkg::LED_W-1:0]       o_led_mode,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cdtsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cdtsr_pkg::TIME_W-1:0]      i_cfg_data
);
    import cdtsr_pkg::*;

    localparam int JOB_W = $bits(t_job);
    localparam int RES_W = $bits(t_result);

    logic    job_push;
    logic    job_full;
    logic    job_empty;
    logic    job_pop;
    t_job    job_in;
    t_job    job_out;
    logic    res_push;
    logic    res_full;
    logic    res_take;
    t_result res_in;
    t_result res_out;
    logic    digits_zero;

    assign o_cfg_ready = 1'b1;
    assign full        = job_full;
    assign res_take    = pop && !empty;

    cdtsr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_req_type      (i_req_type),
        .i_elapsed_us    (i_elapsed_us),
        .i_strike_amount (i_strike_amount),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_job_full      (job_full),
        .o_job_push      (job_push),
        .o_job           (job_in)
    );

    cdtsr_fifo #(.W(JOB_W), .DEPTH(MID_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    cdtsr_back #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_pop   (res_take)
    );

    cdtsr_fifo #(.W(RES_W), .DEPTH(OUT_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_digit_a         = res_out.digit_a;
    assign o_digit_b         = res_out.digit_b;
    assign o_digit_c         = res_out.digit_c;
    assign o_digit_d         = res_out.digit_d;
    assign o_colon_on        = res_out.colon_on;
    assign o_expired         = res_out.expired;
    assign o_limit_reached   = res_out.limit_reached;
    assign o_display_changed = res_out.display_changed;
    assign o_strikes_now     = res_out.strikes_now;
    assign o_led_mode        = res_out.led_mode;

    assign digits_zero = (o_digit_a == '0) && (o_digit_b == '0) &&
                         (o_digit_c == '0) && (o_digit_d == '0);

    `CDTSR_ASSERT_NEVER(a_job_overflow, i_clk, i_rst_n, job_push && job_full, "job overflow")
    `CDTSR_ASSERT_NEVER(a_res_overflow, i_clk, i_rst_n, res_push && res_full, "result overflow")
    `CDTSR_ASSERT_IMPLIES(a_expired_zero, i_clk, i_rst_n, !empty && o_expired, digits_zero, "nonzero at expiry")

endmodule

[tb/sv/countdown_timer_strike_rate_test.sv]
// self-checking testbench for the strike-rate countdown timer: predicted readouts vs. dut
module countdown_timer_strike_rate_test;
    import cdtsr_pkg::*;

    localparam longint unsigned TPS = DEF_TICKS_PER_SECOND;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        t_req                 req;
        logic [ELAPSED_W-1:0] elapsed;
        logic [STRIKE_W-1:0]  amount;
    } t_timer_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [1:0]           i_req_type = REQ_START;
    logic [ELAPSED_W-1:0] i_elapsed_us = '0;
    logic [STRIKE_W-1:0]  i_strike_amount = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [DIGIT_W-1:0]   o_digit_a, o_digit_b, o_digit_c, o_digit_d;
    logic                 o_colon_on, o_expired, o_limit_reached, o_display_changed;
    logic [STRIKE_W-1:0]  o_strikes_now;
    logic [LED_W-1:0]     o_led_mode;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_GAME_LEN;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    // predictor state and register copies
    logic [TIME_W-1:0]   remain_ticks = '0;
    logic [STRIKE_W-1:0] strike_cnt = '0;
    logic [15:0]         shown_digits = '0;
    logic [TIME_W-1:0]   cfg_length = GAME_LEN_RESET;
    logic [LIM_W-1:0]    cfg_limit = STRIKE_LIM_RESET;

    t_timer_cmd pending_cmds[$];
    t_result    expected_readouts[$];
    t_timer_cmd cur_cmd;
    t_result    got, want;
    logic       quiet = 1'b0;
    int         mismatches = 0;
    int         stall_cycles = 0;

    countdown_timer_strike_rate dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_req_type(i_req_type), .i_elapsed_us(i_elapsed_us),
        .i_strike_amount(i_strike_amount),
        .empty(empty), .pop(pop),
        .o_digit_a(o_digit_a), .o_digit_b(o_digit_b),
        .o_digit_c(o_digit_c), .o_digit_d(o_digit_d),
        .o_colon_on(o_colon_on), .o_expired(o_expired),
        .o_limit_reached(o_limit_reached), .o_display_changed(o_display_changed),
        .o_strikes_now(o_strikes_now), .o_led_mode(o_led_mode),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [3:0] digit_clamp(input longint unsigned v);
        return (v > 9) ? 4'd9 : v[3:0];
    endfunction

    // applies one item to the predicted timer state and returns the readout
    function automatic t_result advance_timer(input t_timer_cmd cmd);
        longint unsigned t;
        longint unsigned dec;
        longint unsigned el;
        int              sum;
        logic [3:0]      dig [4];
        logic [15:0]     now_digits;
        logic            changed;
        t_result         r;
        changed = 1'b0;
        case (cmd.req)
            REQ_START: remain_ticks = cfg_length;
            REQ_ADD: begin
                sum = int'(strike_cnt) + int'(cmd.amount);
                strike_cnt = (sum > 7) ? STRIKE_MAX : sum[2:0];
            end
            REQ_SET: strike_cnt = cmd.amount;
            default: begin
                el  = cmd.elapsed;
                dec = (el * (64'd4 + strike_cnt) + 64'd3) / 64'd4;
                t   = remain_ticks;
                remain_ticks = (dec >= t) ? '0 : TIME_W'(t - dec);
            end
        endcase
        t = remain_ticks;
        if (t >= 60 * TPS) begin
            dig[0] = digit_clamp(t / (600 * TPS));
            dig[1] = digit_clamp((t % (600 * TPS)) / (60 * TPS));
            dig[2] = digit_clamp((t % (60 * TPS)) / (10 * TPS));
            dig[3] = digit_clamp((t % (10 * TPS)) / TPS);
        end else if (t > 0) begin
            dig[0] = digit_clamp(t / (10 * TPS));
            dig[1] = digit_clamp((t % (10 * TPS)) / TPS);
            dig[2] = digit_clamp((t % TPS) / (TPS / 10));
            dig[3] = digit_clamp((t % (TPS / 10)) / (TPS / 100));
        end else begin
            dig = '{4'd0, 4'd0, 4'd0, 4'd0};
        end
        now_digits = {dig[0], dig[1], dig[2], dig[3]};
        if (cmd.req == REQ_TICK) begin
            // under a minute only the seconds digits count as a change
            if (t >= 60 * TPS) changed = (now_digits != shown_digits);
            else changed = (now_digits[15:8] != shown_digits[15:8]);
            if (changed) shown_digits = now_digits;
        end
        r.digit_a         = dig[0];
        r.digit_b         = dig[1];
        r.digit_c         = dig[2];
        r.digit_d         = dig[3];
        r.colon_on        = (t > 0);
        r.expired         = (t == 0);
        r.limit_reached   = (strike_cnt >= {1'b0, cfg_limit});
        r.display_changed = changed;
        r.strikes_now     = strike_cnt;
        r.led_mode        = (strike_cnt > 3) ? LED_BOTH_ON : strike_cnt[1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) expected_readouts.push_back(advance_timer(cur_cmd));
            if (!push || !full) begin
                if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 30)) begin
                    cur_cmd = pending_cmds.pop_front();
                    push            <= 1'b1;
                    i_req_type      <= cur_cmd.req;
                    i_elapsed_us    <= cur_cmd.elapsed;
                    i_strike_amount <= cur_cmd.amount;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string field, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{o_digit_a, o_digit_b, o_digit_c, o_digit_d, o_colon_on, o_expired,
                        o_limit_reached, o_display_changed, o_strikes_now, o_led_mode};
                if (expected_readouts.size() == 0) begin
                    $display("%0t: unexpected readout, expected none actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_readouts.pop_front();
                    check_field("digit_a", want.digit_a, got.digit_a);
                    check_field("digit_b", want.digit_b, got.digit_b);
                    check_field("digit_c", want.digit_c, got.digit_c);
                    check_field("digit_d", want.digit_d, got.digit_d);
                    check_field("colon_on", want.colon_on, got.colon_on);
                    check_field("expired", want.expired, got.expired);
                    check_field("limit_reached", want.limit_reached, got.limit_reached);
                    check_field("display_changed", want.display_changed,
                                got.display_changed);
                    check_field("strikes_now", want.strikes_now, got.strikes_now);
                    check_field("led_mode", want.led_mode, got.led_mode);
                end
            end
            pop <= quiet || ($urandom_range(99) >= 30);
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_cmd(input t_req req, input logic [ELAPSED_W-1:0] elapsed,
                           input logic [STRIKE_W-1:0] amount);
        t_timer_cmd c;
        c.req     = req;
        c.elapsed = elapsed;
        c.amount  = amount;
        pending_cmds.push_back(c);
    endtask

    // mostly ticks after a start, with strike changes and restarts mixed in
    task automatic add_random_cmds(input int n);
        int                   sel;
        t_req                 req;
        logic [ELAPSED_W-1:0] el;
        add_cmd(REQ_START, ELAPSED_W'($urandom()), STRIKE_W'($urandom()));
        repeat (n - 1) begin
            sel = $urandom_range(99);
            if (sel < 10) req = REQ_START;
            else if (sel < 70) req = REQ_TICK;
            else if (sel < 85) req = REQ_ADD;
            else req = REQ_SET;
            sel = $urandom_range(99);
            if (sel < 20) el = ELAPSED_W'($urandom());
            else if (sel < 60) el = ELAPSED_W'($urandom_range(1000000));
            else el = ELAPSED_W'($urandom_range(20000));
            add_cmd(req, el, STRIKE_W'($urandom_range(7)));
        end
    endtask

    // checked between edges so the driver and monitor have settled
    task automatic drain;
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || push || expected_readouts.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_GAME_LEN) cfg_length = val;
        else if (idx == CFG_STRIKE_LIMIT) cfg_limit = val[LIM_W-1:0];
        @(posedge i_clk);
    endtask

    initial begin
        do @(posedge i_clk);
        while (!i_rst_n);

        // directed part at reset settings
        add_cmd(REQ_TICK, 24'd0, 3'd0);        // tick with nothing loaded
        add_cmd(REQ_START, 24'd0, 3'd0);
        add_cmd(REQ_TICK, 24'd0, 3'd0);
        add_cmd(REQ_TICK, 24'd1, 3'd0);
        add_cmd(REQ_TICK, 24'd999999, 3'd7);
        add_cmd(REQ_ADD, 24'd0, 3'd0);
        add_cmd(REQ_ADD, 24'd0, 3'd3);
        add_cmd(REQ_TICK, 24'd3, 3'd0);        // rounding up of the scaled decrement
        add_cmd(REQ_ADD, 24'hFFFFFF, 3'd7);    // add past seven
        add_cmd(REQ_ADD, 24'd0, 3'd1);
        add_cmd(REQ_TICK, 24'hFFFFFF, 3'd0);
        add_cmd(REQ_SET, 24'd0, 3'd0);
        add_cmd(REQ_SET, 24'd0, 3'd5);
        add_cmd(REQ_SET, 24'd0, 3'd2);
        add_cmd(REQ_SET, 24'd0, 3'd1);
        add_cmd(REQ_SET, 24'd0, 3'd7);
        repeat (7) add_cmd(REQ_TICK, 24'hFFFFFF, 3'd0);  // runs out, then ticks at zero
        add_cmd(REQ_START, 24'd0, 3'd0);
        add_random_cmds(70);
        drain();

        write_reg(CFG_GAME_LEN, 31'd0);
        write_reg(CFG_STRIKE_LIMIT, 31'd1);
        add_random_cmds(80);
        drain();

        write_reg(CFG_GAME_LEN, 31'h7FFFFFFF);
        write_reg(CFG_STRIKE_LIMIT, 31'd3);
        add_random_cmds(80);
        drain();

        // just under a minute; unused register indexes are written too
        write_reg(CFG_GAME_LEN, 31'd59999999);
        write_reg(CFG_STRIKE_LIMIT, 31'd2);
        write_reg(2'd2, 31'h7FFFFFFF);
        write_reg(2'd3, 31'h55555555);
        add_random_cmds(80);
        drain();

        // exactly one minute, limit zero, no idling on either side
        write_reg(CFG_GAME_LEN, 31'd60000000);
        write_reg(CFG_STRIKE_LIMIT, 31'd0);
        quiet <= 1'b1;
        add_random_cmds(80);
        drain();
        quiet <= 1'b0;

        repeat (2) begin
            write_reg(CFG_GAME_LEN, TIME_W'($urandom_range(120000000)));
            write_reg(CFG_STRIKE_LIMIT, TIME_W'($urandom_range(3)));
            add_random_cmds(80);
            drain();
        end

        if (mismatches == 0 && expected_readouts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
